// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the base-36 block encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: design/b36e_pkg.sv
// Types, constants and digit arithmetic for the base-36 block encoder.
// No dependencies; imported by the interfaces, the cell, the top level and the testbench.
package b36e_pkg;

	localparam int DIGITS      = 11;
	localparam int DIG_W       = 6;
	localparam int CNT_W       = 4;
	localparam int HELD_W      = 3;
	localparam int BLOCK_BYTES = 7;
	localparam int CHAR_W      = 7;

	typedef logic [DIG_W-1:0]  digit_t;
	typedef logic [1:0]        carry2_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [HELD_W-1:0] held_t;

	// per-cycle control for the cell row
	typedef struct packed {
		logic en;
		logic clr;
	} cell_ctl_t;

	// carries of the two radix-4 sub-steps done together in the same cycle
	typedef struct packed {
		carry2_t a;
		carry2_t b;
	} carry_t;

	// characters emitted for a block of n bytes
	function automatic cnt_t chars_for_bytes(input held_t n);
		cnt_t r;
		case (n)
			3'd1: r = 4'd2;
			3'd2: r = 4'd4;
			3'd3: r = 4'd5;
			3'd4: r = 4'd7;
			3'd5: r = 4'd8;
			3'd6: r = 4'd10;
			3'd7: r = 4'd11;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// lowercase ASCII for one base-36 digit
	function automatic logic [CHAR_W-1:0] digit_ascii(input digit_t d);
		logic [CHAR_W-1:0] r;
		if (d < 6'd10) begin
			r = CHAR_W'(d) + 7'd48;
		end else begin
			r = CHAR_W'(d) + 7'd87;
		end
		return r;
	endfunction

	// carry out of 4*d: floor(4d/36), independent of the carry in
	function automatic carry2_t carry_of(input digit_t d);
		carry2_t q;
		if (d >= 6'd27) begin
			q = 2'd3;
		end else if (d >= 6'd18) begin
			q = 2'd2;
		end else if (d >= 6'd9) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return q;
	endfunction

	// new digit of 4*d + c mod 36; 4*(d mod 9) + c never exceeds 35
	function automatic digit_t digit_step(input digit_t d, input carry2_t c);
		carry2_t q;
		digit_t  base;
		q = carry_of(d);
		case (q)
			2'd3: base = d - 6'd27;
			2'd2: base = d - 6'd18;
			2'd1: base = d - 6'd9;
			default: base = d;
		endcase
		return {base[3:0], 2'b00} + {4'b0000, c};
	endfunction

endpackage

// File: design/b36e_if.sv
// Valid/ready channel interfaces for byte input and character output.
// Depends on b36e_pkg for the character width.
interface b36e_in_if import b36e_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b36e_out_if import b36e_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              block_end;
	logic              message_end;

	modport source (output valid, output char_code, output block_end, output message_end,
		input ready);
	modport sink (input valid, input char_code, input block_end, input message_end,
		output ready);
endinterface

// File: design/b36e_cell.sv
// One base-36 digit cell: multiplies its digit by 16 per enabled cycle in two radix-4 steps.
// Depends on b36e_pkg; instantiated in a row by base36_block_encoder_top.
module b36e_cell import b36e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  carry_t    cin,
	output carry_t    cout,
	output digit_t    digit
);

	digit_t digit_q;
	digit_t mid;
	digit_t fin;

	// two chained sub-steps; carries out depend only on this cell's own digits
	always_comb begin
		mid    = digit_step(digit_q, cin.a);
		fin    = digit_step(mid, cin.b);
		cout.a = carry_of(digit_q);
		cout.b = carry_of(mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clr) begin
			digit_q <= '0;
		end else if (ctl.en) begin
			digit_q <= fin;
		end
	end

	assign digit = digit_q;

endmodule

// File: design/base36_block_encoder_top.sv
// Top level of the base-36 block encoder: control, cell row and output bank.
// Depends on b36e_pkg, b36e_if, b36e_cell and assert_macros.svh.
//
//  channel  | dir | payload                               | handshake
//  in_ch    | in  | data_byte[7:0], final_byte            | valid/ready
//  out_ch   | out | char_code[6:0], block_end, message_end| valid/ready
//
// Each byte enters the cell row in two halves: the high nibble on the accept
// edge, the low nibble on the next. Once a block closes, its digits move into
// the output bank, and characters drain one per cycle while the receiver is
// ready, as the next block builds. The move waits until the bank is empty or its
// last character leaves. Reset clears the cells, counters and control at once.
`include "assert_macros.svh"

module base36_block_encoder_top import b36e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	b36e_in_if.sink    in_ch,
	b36e_out_if.source out_ch
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LO    = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]  state_q;
	logic [3:0]  lo_nib_q;
	held_t       held_q;
	held_t       nbytes_q;
	logic        close_q;
	logic        final_q;

	digit_t      out_dig_q [DIGITS];
	cnt_t        out_cnt_q;
	logic        out_last_q;

	logic        in_fire;
	logic        out_fire;
	logic        bank_free;
	logic        load;
	held_t       count;
	logic        close_now;
	logic [3:0]  nibble;
	cnt_t        out_idx;

	cell_ctl_t   cell_ctl;
	carry_t      cell_cin  [DIGITS];
	carry_t      cell_cout [DIGITS];
	digit_t      cell_dig  [DIGITS];

	// handshakes
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;

	assign count     = held_q + 3'd1;
	assign close_now = (count == HELD_W'(BLOCK_BYTES)) || in_ch.final_byte;

	// bank takes a new block when empty or emptying this cycle
	assign bank_free = (out_cnt_q == '0) || ((out_cnt_q == 4'd1) && out_fire);
	assign load      = (state_q == ST_FLUSH) && bank_free;

	// nibble fed into the least significant cell
	assign nibble = in_fire ? in_ch.data_byte[7:4] : lo_nib_q;

	assign cell_ctl.en  = in_fire || (state_q == ST_LO);
	assign cell_ctl.clr = load;

	// cell row, carries flow toward the most significant digit
	assign cell_cin[0].a = nibble[3:2];
	assign cell_cin[0].b = nibble[1:0];

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign cell_cin[i] = cell_cout[i-1];
		end
		b36e_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.cin    (cell_cin[i]),
			.cout   (cell_cout[i]),
			.digit  (cell_dig[i])
		);
	end

	// sequencing of byte halves and block close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			close_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LO;
						close_q <= close_now;
						held_q  <= close_now ? '0 : count;
					end
				end
				ST_LO: begin
					state_q <= close_q ? ST_FLUSH : ST_IDLE;
				end
				ST_FLUSH: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload captured with each item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lo_nib_q <= in_ch.data_byte[3:0];
			nbytes_q <= count;
			final_q  <= in_ch.final_byte;
		end
	end

	// output bank count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (load) begin
			out_cnt_q <= chars_for_bytes(nbytes_q);
		end else if (out_fire) begin
			out_cnt_q <= out_cnt_q - 4'd1;
		end
	end

	// output bank digits and message flag
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < DIGITS; i++) begin
				out_dig_q[i] <= cell_dig[i];
			end
			out_last_q <= final_q;
		end
	end

	// most significant remaining digit goes out first
	assign out_idx            = out_cnt_q - 4'd1;
	assign out_ch.valid       = (out_cnt_q != '0);
	assign out_ch.char_code   = digit_ascii(out_dig_q[out_idx]);
	assign out_ch.block_end   = (out_cnt_q == 4'd1);
	assign out_ch.message_end = (out_cnt_q == 4'd1) && out_last_q;

	// checks
	`ASSERT_ALWAYS(a_busy_after_accept, clk, arst_n, in_fire |=> !in_ch.ready)
	`ASSERT_NEVER(a_held_range, clk, arst_n, held_q > 3'd6)
	`ASSERT_NEVER(a_bank_range, clk, arst_n, out_cnt_q > 4'd11)
	`ASSERT_ALWAYS(a_top_no_carry, clk, arst_n, cell_ctl.en |-> (cell_cout[DIGITS-1] == '0))
	`ASSERT_ALWAYS(a_bank_drains, clk, arst_n,
		(out_fire && (out_cnt_q == 4'd1) && !load) |=> !out_ch.valid)

endmodule

// File: sim/base36_block_encoder_top_tb.sv
// Self-checking testbench for the base-36 block encoder top level.
// Depends on b36e_pkg, the b36e_in_if/b36e_out_if interfaces and the RTL.
module base36_block_encoder_top_tb import b36e_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              blk_end;
		logic              msg_end;
	} b36_char_t;

	localparam int    RADIX     = 36;
	localparam string DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";
	localparam int    CHARS_PER_BLOCK [8] = '{0, 2, 4, 5, 7, 8, 10, 11};
	localparam int    DRAIN_LIMIT = 20000;

	logic clk;
	logic arst_n;

	b36e_in_if  in_ch ();
	b36e_out_if out_ch ();

	base36_block_encoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state: open block value and its byte count
	logic [55:0] acc_value;
	int          acc_bytes;
	b36_char_t   expected_chars [$];

	int  mismatch_count;
	int  bytes_sent;
	int  messages_sent;
	int  chars_checked;
	bit  in_gap_on;
	bit  out_stall_on;
	int  long_hold_req;
	int  ready_hold;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("Timeout at %0t", $time);
		$display("RESULT: ERROR");
		$finish;
	end

	// random gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 25);
	endfunction

	// byte values biased toward the extremes
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hff;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// shift one byte into the block; on close, queue the block's characters
	function automatic void absorb_byte(input logic [7:0] d, input logic fin);
		logic [55:0] v;
		logic [5:0]  dig [DIGITS];
		int          cnt;
		int          n;
		b36_char_t   c;
		acc_value = {acc_value[47:0], d};
		cnt = acc_bytes + 1;
		if (cnt < BLOCK_BYTES && !fin) begin
			acc_bytes = cnt;
			return;
		end
		n = CHARS_PER_BLOCK[cnt];
		v = acc_value;
		for (int i = n - 1; i >= 0; i--) begin
			dig[i] = 6'(v % RADIX);
			v = v / RADIX;
		end
		for (int i = 0; i < n; i++) begin
			c.code    = CHAR_W'(DIGIT_SET[dig[i]]);
			c.blk_end = (i == n - 1);
			c.msg_end = (i == n - 1) && fin;
			expected_chars.push_back(c);
		end
		acc_value = '0;
		acc_bytes = 0;
	endfunction

	// offer one item; entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] d, input logic fin);
		int gap;
		gap = in_gap_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid      = 1'b1;
		in_ch.data_byte  = d;
		in_ch.final_byte = fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		absorb_byte(d, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(pick_byte(), i == len - 1);
		end
		messages_sent++;
	endtask

	// hold the input until every queued character has been seen
	task automatic wait_all_chars();
		int n;
		in_ch.valid = 1'b0;
		n = 0;
		while (expected_chars.size() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, expected_chars.size());
			mismatch_count++;
		end
	endtask

	// output ready: random stalls, plus long holds on request
	initial begin
		out_ch.ready = 1'b0;
		ready_hold   = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req > 0) begin
				ready_hold    = long_hold_req;
				long_hold_req = 0;
			end
			if (ready_hold > 0) begin
				out_ch.ready = 1'b0;
				ready_hold--;
			end else if (out_stall_on && $urandom_range(0, 99) < 30) begin
				out_ch.ready = 1'b0;
				ready_hold   = pick_gap();
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// compare each accepted character with the oldest expectation
	always @(posedge clk) begin
		b36_char_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, got code %0d",
					$time, out_ch.char_code);
				mismatch_count++;
			end else begin
				e = expected_chars.pop_front();
				chars_checked++;
				if (out_ch.char_code !== e.code) begin
					$display("%0t: char_code mismatch: expected %0d, got %0d",
						$time, e.code, out_ch.char_code);
					mismatch_count++;
				end
				if (out_ch.block_end !== e.blk_end) begin
					$display("%0t: block_end mismatch: expected %0b, got %0b",
						$time, e.blk_end, out_ch.block_end);
					mismatch_count++;
				end
				if (out_ch.message_end !== e.msg_end) begin
					$display("%0t: message_end mismatch: expected %0b, got %0b",
						$time, e.msg_end, out_ch.message_end);
					mismatch_count++;
				end
			end
		end
	end

	// single-byte messages at both extremes, a final full block, a six-byte
	// tail, and a full block that closes itself, then a two-byte final tail
	task automatic test_directed();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		for (int i = 0; i < 7; i++) begin
			send_byte(8'hff, i == 6);
		end
		for (int i = 0; i < 6; i++) begin
			send_byte(8'h80 >> i, i == 5);
		end
		for (int i = 0; i < 7; i++) begin
			send_byte(8'h5a, 1'b0);
		end
		send_byte(8'h01, 1'b0);
		send_byte(8'hfe, 1'b1);
		messages_sent += 5;
		wait_all_chars();
	endtask

	// random messages; idling switched per message so some stretches run flat out
	task automatic test_random_messages(input int n_bytes);
		int start;
		int r;
		int len;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			r = $urandom_range(0, 9);
			in_gap_on    = (r < 7) || (r == 8);
			out_stall_on = (r < 8);
			r = $urandom_range(0, 9);
			if (r < 6) begin
				len = $urandom_range(1, 14);
			end else if (r < 9) begin
				len = $urandom_range(15, 30);
			end else begin
				len = 7 * $urandom_range(1, 3);
			end
			send_message(len);
			if ($urandom_range(0, 9) == 0) begin
				wait_all_chars();
			end
		end
		in_gap_on    = 1'b1;
		out_stall_on = 1'b1;
		wait_all_chars();
	endtask

	// long receiver hold while the sender keeps offering items back to back
	task automatic test_output_hold();
		in_gap_on     = 1'b0;
		long_hold_req = 250;
		send_message(14);
		send_message(9);
		send_message(7);
		in_gap_on = 1'b1;
		wait_all_chars();
	endtask

	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.data_byte  = 8'h00;
		in_ch.final_byte = 1'b0;
		acc_value        = '0;
		acc_bytes        = 0;
		mismatch_count   = 0;
		bytes_sent       = 0;
		messages_sent    = 0;
		chars_checked    = 0;
		in_gap_on        = 1'b1;
		out_stall_on     = 1'b1;
		long_hold_req    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_messages(95);
		test_output_hold();
		test_random_messages(95);

		// let any stray characters show up before the verdict
		wait_all_chars();
		repeat (40) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d characters left over", $time, expected_chars.size());
			mismatch_count++;
		end
		$display("Sent %0d bytes in %0d messages, checked %0d characters,", bytes_sent,
			messages_sent, chars_checked);
		$display("with random gaps on both sides, a long output hold and drain pauses.");
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/b36e_pkg.sv
design/b36e_if.sv
design/b36e_cell.sv
design/base36_block_encoder_top.sv
sim/base36_block_encoder_top_tb.sv
